// ----- src/hssre_pkg.sv -----
// Shared types, field positions and the half-step coil table for the stepper run engine.
package hssre_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int HITS_WIDTH  = 4;
    localparam int PHASE_WIDTH = 3;
    localparam int COIL_WIDTH  = 4;

    localparam logic [HITS_WIDTH-1:0] HITS_MAX       = '1;
    localparam logic [HITS_WIDTH-1:0] DEBOUNCE_RESET = HITS_WIDTH'(2);

    // Input tdata layout, lowest bit first.
    localparam int S_DIR_BIT      = 0;
    localparam int S_TARGET_LSB   = 1;
    localparam int S_WDOG_LSB     = S_TARGET_LSB + COUNT_WIDTH;
    localparam int S_USE_OPEN_BIT = S_WDOG_LSB + COUNT_WIDTH;
    localparam int S_USE_CLSD_BIT = S_USE_OPEN_BIT + 1;
    localparam int S_OPEN_LVL_BIT = S_USE_CLSD_BIT + 1;
    localparam int S_CLSD_LVL_BIT = S_OPEN_LVL_BIT + 1;
    localparam int S_USED_BITS    = S_CLSD_LVL_BIT + 1;
    localparam int S_TDATA_WIDTH  = ((S_USED_BITS + 7) / 8) * 8;

    // Result tdata layout, lowest bit first.
    localparam int M_COIL_LSB     = 0;
    localparam int M_RUNNING_BIT  = M_COIL_LSB + COIL_WIDTH;
    localparam int M_ENDED_BIT    = M_RUNNING_BIT + 1;
    localparam int M_CODE_LSB     = M_ENDED_BIT + 1;
    localparam int M_STEPS_LSB    = M_CODE_LSB + 3;
    localparam int M_USED_BITS    = M_STEPS_LSB + COUNT_WIDTH;
    localparam int M_TDATA_WIDTH  = ((M_USED_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_TICK  = 2'd1,
        OP_STOP  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        END_DONE       = 3'd0,
        END_OPEN_LIMIT = 3'd1,
        END_CLSD_LIMIT = 3'd2,
        END_WATCHDOG   = 3'd3,
        END_STOPPED    = 3'd4
    } end_code_t;

    // AIN1,AIN2,BIN1,BIN2 on bits 3..0.
    function automatic logic [COIL_WIDTH-1:0] phase_row(input logic [PHASE_WIDTH-1:0] phase);
        logic [COIL_WIDTH-1:0] row;
        unique case (phase)
            3'd0:    row = 4'b1000;
            3'd1:    row = 4'b1010;
            3'd2:    row = 4'b0010;
            3'd3:    row = 4'b0110;
            3'd4:    row = 4'b0100;
            3'd5:    row = 4'b0101;
            3'd6:    row = 4'b0001;
            default: row = 4'b1001;
        endcase
        return row;
    endfunction

endpackage

// ----- src/half_step_stepper_run_engine.sv -----
// Half-step sequencer top level: run state, tick decision and two-entry result buffer.
//
// One request per clock while the result buffer has room: every request (start, step
// tick, stop) is decided in the cycle it is accepted and its result is registered
// into the output entry, or into the skid entry while the output entry is held. The
// run state (phase, step count, debounce counters) is updated at the accept edge,
// so back-to-back ticks see each other's effect. A second result entry absorbs
// one request while the master side stalls; s_axis_tready falls only when both
// entries are full. Configuration (debounce_reads) is taken every cycle and
// must only be written while the block is idle.
module half_step_stepper_run_engine (
    input  logic                                aclk,
    input  logic                                aresetn,
    // cfg_data: debounce_reads[3:0]
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hssre_pkg::HITS_WIDTH-1:0]    cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // s_axis_tdata: toward_open[0], step_target[16:1], watchdog_limit[32:17],
    // use_open_limit[33], use_closed_limit[34], open_switch_level[35],
    // closed_switch_level[36], zero fill above
    input  logic [hssre_pkg::S_TDATA_WIDTH-1:0] s_axis_tdata,
    // s_axis_tuser: op[1:0]
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // m_axis_tdata: coil_drive[3:0], running[4], run_ended[5], end_code[8:6],
    // steps_count[24:9], zero fill above
    output logic [hssre_pkg::M_TDATA_WIDTH-1:0] m_axis_tdata
);
    import hssre_pkg::*;

    // Run state
    logic                   active_reg,   active_next;
    logic [PHASE_WIDTH-1:0] phase_reg,    phase_next;
    logic [HITS_WIDTH-1:0]  open_reads_reg, open_reads_next;
    logic [HITS_WIDTH-1:0]  clsd_hits_reg, clsd_hits_next;
    logic [COUNT_WIDTH-1:0] steps_reg,    steps_next;
    end_code_t              last_code_reg, last_code_next;
    logic                   stop_reg,     stop_next;
    logic                   dir_reg,      dir_next;
    logic [COUNT_WIDTH-1:0] target_reg,   target_next;
    logic [COUNT_WIDTH-1:0] wdog_reg,     wdog_next;
    logic [1:0]             lim_en_reg,   lim_en_next;
    logic [HITS_WIDTH-1:0]  debounce_reg;

    // Result buffer: output entry plus one skid entry
    logic                     out_valid_reg;
    logic [M_TDATA_WIDTH-1:0] out_data_reg;
    logic                     skid_valid_reg;
    logic [M_TDATA_WIDTH-1:0] skid_data_reg;

    // Request fields
    op_t                    in_op;
    logic                   in_dir;
    logic [COUNT_WIDTH-1:0] in_target;
    logic [COUNT_WIDTH-1:0] in_wdog;
    logic                   in_use_open;
    logic                   in_use_clsd;
    logic                   in_open_lvl;
    logic                   in_clsd_lvl;

    logic                     accept;
    logic                     drain;
    logic                     ended;
    logic                     stop_run;
    end_code_t                stop_code;
    logic [HITS_WIDTH-1:0]    open_cand;
    logic [HITS_WIDTH-1:0]    clsd_cand;
    logic [M_TDATA_WIDTH-1:0] result;

    assign in_op       = op_t'(s_axis_tuser);
    assign in_dir      = s_axis_tdata[S_DIR_BIT];
    assign in_target   = s_axis_tdata[S_TARGET_LSB +: COUNT_WIDTH];
    assign in_wdog     = s_axis_tdata[S_WDOG_LSB +: COUNT_WIDTH];
    assign in_use_open = s_axis_tdata[S_USE_OPEN_BIT];
    assign in_use_clsd = s_axis_tdata[S_USE_CLSD_BIT];
    assign in_open_lvl = s_axis_tdata[S_OPEN_LVL_BIT];
    assign in_clsd_lvl = s_axis_tdata[S_CLSD_LVL_BIT];

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !skid_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign drain         = out_valid_reg && m_axis_tready;

    // Active-low limit reads: count consecutive lows, saturating; a high clears.
    assign open_cand = in_open_lvl ? '0
                     : ((open_reads_reg == HITS_MAX) ? HITS_MAX : open_reads_reg + 1'b1);
    assign clsd_cand = in_clsd_lvl ? '0
                     : ((clsd_hits_reg == HITS_MAX) ? HITS_MAX : clsd_hits_reg + 1'b1);

    // Decide the request against the current run state.
    always_comb begin
        active_next     = active_reg;
        phase_next      = phase_reg;
        open_reads_next = open_reads_reg;
        clsd_hits_next  = clsd_hits_reg;
        steps_next      = steps_reg;
        last_code_next  = last_code_reg;
        stop_next       = stop_reg;
        dir_next        = dir_reg;
        target_next     = target_reg;
        wdog_next       = wdog_reg;
        lim_en_next     = lim_en_reg;
        ended           = 1'b0;
        stop_run        = 1'b0;
        stop_code       = END_DONE;

        unique case (in_op)
            OP_START: begin
                // Drop any run in progress and latch the new settings.
                dir_next        = in_dir;
                target_next     = in_target;
                wdog_next       = in_wdog;
                lim_en_next     = {in_use_clsd, in_use_open};
                stop_next       = 1'b0;
                phase_next      = '0;
                open_reads_next = '0;
                clsd_hits_next  = '0;
                steps_next      = '0;
                last_code_next  = END_DONE;
                active_next     = (in_target != '0);
                ended           = (in_target == '0);
            end
            OP_STOP: begin
                stop_next = 1'b1;
            end
            OP_TICK: begin
                if (active_reg) begin
                    if (stop_reg) begin
                        stop_run  = 1'b1;
                        stop_code = END_STOPPED;
                    end else begin
                        if (lim_en_reg[0]) begin
                            open_reads_next = open_cand;
                            if (open_cand >= debounce_reg) begin
                                stop_run  = 1'b1;
                                stop_code = END_OPEN_LIMIT;
                            end
                        end
                        if (!stop_run && lim_en_reg[1]) begin
                            clsd_hits_next = clsd_cand;
                            if (clsd_cand >= debounce_reg) begin
                                stop_run  = 1'b1;
                                stop_code = END_CLSD_LIMIT;
                            end
                        end
                        if (!stop_run) begin
                            priority if (steps_reg >= target_reg) begin
                                stop_run  = 1'b1;
                                stop_code = END_DONE;
                            end else if (steps_reg >= wdog_reg) begin
                                stop_run  = 1'b1;
                                stop_code = END_WATCHDOG;
                            end
                        end
                    end
                    if (stop_run) begin
                        // End the run with the coils off.
                        last_code_next = stop_code;
                        active_next    = 1'b0;
                        ended          = 1'b1;
                    end else begin
                        // Advance one half-step and count it.
                        phase_next = dir_reg ? phase_reg + 1'b1 : phase_reg - 1'b1;
                        steps_next = steps_reg + 1'b1;
                    end
                end
            end
            default: begin
                // Unused op: report status only.
            end
        endcase

        result                                  = '0;
        result[M_COIL_LSB +: COIL_WIDTH]        = active_next ? phase_row(phase_next) : '0;
        result[M_RUNNING_BIT]                   = active_next;
        result[M_ENDED_BIT]                     = ended;
        result[M_CODE_LSB +: 3]                 = last_code_next;
        result[M_STEPS_LSB +: COUNT_WIDTH]      = steps_next;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg     <= 1'b0;
            phase_reg      <= '0;
            open_reads_reg <= '0;
            clsd_hits_reg  <= '0;
            steps_reg      <= '0;
            last_code_reg  <= END_DONE;
            stop_reg       <= 1'b0;
            dir_reg        <= 1'b0;
            target_reg     <= '0;
            wdog_reg       <= '0;
            lim_en_reg     <= '0;
            debounce_reg   <= DEBOUNCE_RESET;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                debounce_reg <= cfg_data;
            end
            if (accept) begin
                active_reg     <= active_next;
                phase_reg      <= phase_next;
                open_reads_reg <= open_reads_next;
                clsd_hits_reg  <= clsd_hits_next;
                steps_reg      <= steps_next;
                last_code_reg  <= last_code_next;
                stop_reg       <= stop_next;
                dir_reg        <= dir_next;
                target_reg     <= target_next;
                wdog_reg       <= wdog_next;
                lim_en_reg     <= lim_en_next;
            end
            // Hold results in order: output entry first, skid behind it.
            if (skid_valid_reg) begin
                if (drain) begin
                    skid_valid_reg <= 1'b0;
                end
            end else if (accept) begin
                if (!out_valid_reg || drain) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (drain) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (drain) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (accept) begin
            if (!out_valid_reg || drain) begin
                out_data_reg <= result;
            end else begin
                skid_data_reg <= result;
            end
        end
    end

endmodule

// ----- src/hssre_checker.sv -----
// Port-level checks for the stepper run engine, bound to the top level.
module hssre_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [hssre_pkg::M_TDATA_WIDTH-1:0] m_axis_tdata
);
    import hssre_pkg::*;

    logic [COIL_WIDTH-1:0] coil;
    logic                  running;
    logic                  ended;
    logic [2:0]            code;

    assign coil    = m_axis_tdata[M_COIL_LSB +: COIL_WIDTH];
    assign running = m_axis_tdata[M_RUNNING_BIT];
    assign ended   = m_axis_tdata[M_ENDED_BIT];
    assign code    = m_axis_tdata[M_CODE_LSB +: 3];

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Coils are off whenever no run is active.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !running |-> coil == '0)
        else $error("coils driven while idle");

    // A running result drives a nonzero coil pattern and never reports an end.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && running |-> coil != '0 && !ended)
        else $error("running result inconsistent");

    // End codes stay within the defined set.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> code == END_DONE || code == END_OPEN_LIMIT
            || code == END_CLSD_LIMIT || code == END_WATCHDOG || code == END_STOPPED)
        else $error("undefined end code");

endmodule

bind half_step_stepper_run_engine hssre_checker u_hssre_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- test/half_step_stepper_run_engine_test.sv -----
// Self-checking testbench for the half-step stepper run engine: directed and random requests.
module half_step_stepper_run_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hssre_pkg::*;

    // Unused op code; the block must treat it as a status read.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Coil rows AIN1,AIN2,BIN1,BIN2 on bits 3..0, indexed by phase.
    localparam logic [COIL_WIDTH-1:0] COIL_ROWS [8] = '{
        4'h8, 4'hA, 4'h2, 4'h6, 4'h4, 4'h5, 4'h1, 4'h9
    };

    localparam int PHASE_COUNT     = 7;
    localparam int PHASE_REQUESTS  = 160;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int MAX_PRINTED     = 40;

    typedef struct {
        logic [COIL_WIDTH-1:0]  coil;
        logic                   running;
        logic                   ended;
        end_code_t              code;
        logic [COUNT_WIDTH-1:0] steps;
    } run_status_t;

    // Tracks the run state of the block and the status replies still owed by it.
    class run_scoreboard;
        logic [HITS_WIDTH-1:0]  debounce;
        bit                     active;
        bit                     stop_latched;
        bit                     upward;
        bit                     use_open;
        bit                     use_clsd;
        logic [PHASE_WIDTH-1:0] phase;
        logic [HITS_WIDTH-1:0]  open_reads;
        logic [HITS_WIDTH-1:0]  clsd_hits;
        logic [COUNT_WIDTH-1:0] steps;
        logic [COUNT_WIDTH-1:0] target;
        logic [COUNT_WIDTH-1:0] wdog;
        end_code_t              last_code;
        run_status_t            owed_status_q[$];
        int unsigned            mismatches;

        function new();
            debounce     = DEBOUNCE_RESET;
            active       = 1'b0;
            stop_latched = 1'b0;
            upward       = 1'b0;
            use_open     = 1'b0;
            use_clsd     = 1'b0;
            phase        = '0;
            open_reads   = '0;
            clsd_hits    = '0;
            steps        = '0;
            target       = '0;
            wdog         = '0;
            last_code    = END_DONE;
            mismatches   = 0;
        endfunction

        function void set_debounce(logic [HITS_WIDTH-1:0] reads);
            debounce = reads;
        endfunction

        function int unsigned pending();
            return owed_status_q.size();
        endfunction

        task report_mismatch(string what);
            if (mismatches < MAX_PRINTED) begin
                $display("[%0t] mismatch: %s", $realtime, what);
            end
            mismatches++;
        endtask

        // An inactive (high) level clears the count; an active (low) read counts up, saturating.
        function logic [HITS_WIDTH-1:0] bump_hits(logic [HITS_WIDTH-1:0] hits, logic level);
            if (level) begin
                return '0;
            end
            return (hits == HITS_MAX) ? HITS_MAX : hits + 1'b1;
        endfunction

        // Advance the run state for one accepted request and queue the status it yields.
        function void note_request(logic [1:0] op, logic [S_TDATA_WIDTH-1:0] data);
            run_status_t status;
            bit          ended;
            bit          stopping;
            end_code_t   why;
            ended    = 1'b0;
            stopping = 1'b0;
            why      = END_DONE;
            case (op)
                OP_START: begin
                    upward       = data[S_DIR_BIT];
                    target       = data[S_TARGET_LSB +: COUNT_WIDTH];
                    wdog         = data[S_WDOG_LSB +: COUNT_WIDTH];
                    use_open     = data[S_USE_OPEN_BIT];
                    use_clsd     = data[S_USE_CLSD_BIT];
                    stop_latched = 1'b0;
                    phase        = '0;
                    open_reads   = '0;
                    clsd_hits    = '0;
                    steps        = '0;
                    last_code    = END_DONE;
                    active       = (target != '0);
                    ended        = (target == '0);
                end
                OP_STOP: begin
                    stop_latched = 1'b1;
                end
                OP_TICK: begin
                    if (active) begin
                        if (stop_latched) begin
                            stopping = 1'b1;
                            why      = END_STOPPED;
                        end else begin
                            // Open limit wins over closed; both win over the counts.
                            if (use_open) begin
                                open_reads = bump_hits(open_reads, data[S_OPEN_LVL_BIT]);
                                if (open_reads >= debounce) begin
                                    stopping = 1'b1;
                                    why      = END_OPEN_LIMIT;
                                end
                            end
                            if (!stopping && use_clsd) begin
                                clsd_hits = bump_hits(clsd_hits, data[S_CLSD_LVL_BIT]);
                                if (clsd_hits >= debounce) begin
                                    stopping = 1'b1;
                                    why      = END_CLSD_LIMIT;
                                end
                            end
                            if (!stopping) begin
                                if (steps >= target) begin
                                    stopping = 1'b1;
                                    why      = END_DONE;
                                end else if (steps >= wdog) begin
                                    stopping = 1'b1;
                                    why      = END_WATCHDOG;
                                end
                            end
                        end
                        if (stopping) begin
                            last_code = why;
                            active    = 1'b0;
                            ended     = 1'b1;
                        end else begin
                            phase = upward ? phase + 1'b1 : phase - 1'b1;
                            steps = steps + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            status.coil    = active ? COIL_ROWS[phase] : '0;
            status.running = active;
            status.ended   = ended;
            status.code    = last_code;
            status.steps   = steps;
            owed_status_q.push_back(status);
        endfunction

        task check_result(logic [M_TDATA_WIDTH-1:0] data);
            run_status_t want;
            if (owed_status_q.size() == 0) begin
                report_mismatch($sformatf("status %h with no request outstanding", data));
                return;
            end
            want = owed_status_q.pop_front();
            if (data[M_COIL_LSB +: COIL_WIDTH] !== want.coil) begin
                report_mismatch($sformatf("coil_drive %h, want %h",
                    data[M_COIL_LSB +: COIL_WIDTH], want.coil));
            end
            if (data[M_RUNNING_BIT] !== want.running) begin
                report_mismatch($sformatf("running %b, want %b",
                    data[M_RUNNING_BIT], want.running));
            end
            if (data[M_ENDED_BIT] !== want.ended) begin
                report_mismatch($sformatf("run_ended %b, want %b",
                    data[M_ENDED_BIT], want.ended));
            end
            if (data[M_CODE_LSB +: 3] !== want.code) begin
                report_mismatch($sformatf("end_code %0d, want %0d",
                    data[M_CODE_LSB +: 3], want.code));
            end
            if (data[M_STEPS_LSB +: COUNT_WIDTH] !== want.steps) begin
                report_mismatch($sformatf("steps_count %0d, want %0d",
                    data[M_STEPS_LSB +: COUNT_WIDTH], want.steps));
            end
        endtask
    endclass

    logic                     aclk          = 1'b0;
    logic                     aresetn       = 1'b0;
    logic                     cfg_valid     = 1'b0;
    logic                     cfg_ready;
    logic [HITS_WIDTH-1:0]    cfg_data      = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    // s_axis_tdata: toward_open, step_target, watchdog_limit, use_open_limit,
    // use_closed_limit, open_switch_level, closed_switch_level, zero fill
    logic [S_TDATA_WIDTH-1:0] s_axis_tdata  = '0;
    // s_axis_tuser: op
    logic [1:0]               s_axis_tuser  = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    // m_axis_tdata: coil_drive, running, run_ended, end_code, steps_count, zero fill
    logic [M_TDATA_WIDTH-1:0] m_axis_tdata;

    run_scoreboard sb;
    int unsigned   requests_sent    = 0;
    int unsigned   tx_idle_pct      = 0;
    bit            quiet_tail       = 1'b0;
    bit            hold_off_request = 1'b0;

    half_step_stepper_run_engine dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Note every accepted request; the reply can come no earlier than the next edge.
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            sb.note_request(s_axis_tuser, s_axis_tdata);
        end
    end

    // Check every accepted status reply against the oldest one owed.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata);
        end
    end

    // Pack the request fields into tdata, first field lowest, zero fill on top.
    function automatic logic [S_TDATA_WIDTH-1:0] request_bits(
        logic dir, logic [COUNT_WIDTH-1:0] target, logic [COUNT_WIDTH-1:0] wdog,
        logic use_open, logic use_clsd, logic open_lvl, logic clsd_lvl);
        logic [S_TDATA_WIDTH-1:0] bits;
        bits                              = '0;
        bits[S_DIR_BIT]                   = dir;
        bits[S_TARGET_LSB +: COUNT_WIDTH] = target;
        bits[S_WDOG_LSB +: COUNT_WIDTH]   = wdog;
        bits[S_USE_OPEN_BIT]              = use_open;
        bits[S_USE_CLSD_BIT]              = use_clsd;
        bits[S_OPEN_LVL_BIT]              = open_lvl;
        bits[S_CLSD_LVL_BIT]              = clsd_lvl;
        return bits;
    endfunction

    // Random content in every field; ticks and stops must ignore what they do not use.
    function automatic logic [S_TDATA_WIDTH-1:0] noise_bits();
        logic [S_TDATA_WIDTH-1:0] bits;
        bits                                   = S_TDATA_WIDTH'({$urandom, $urandom});
        bits[S_TDATA_WIDTH-1:S_USED_BITS]      = '0;
        return bits;
    endfunction

    function automatic int unsigned pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 20;
            default: return 50;
        endcase
    endfunction

    // Offer one request and hold it until taken; sometimes go quiet for a burst.
    task automatic send_request(input logic [1:0] op, input logic [S_TDATA_WIDTH-1:0] data);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= op;
        @(posedge aclk);
        while (!s_axis_tready) begin
            @(posedge aclk);
        end
        requests_sent++;
        if (!quiet_tail && $urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    task automatic write_debounce(input logic [HITS_WIDTH-1:0] reads);
        cfg_valid <= 1'b1;
        cfg_data  <= reads;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        sb.set_debounce(reads);
    endtask

    // Drop valid and wait for every owed reply; the block is then idle.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic directed_requests();
        // Idle block: tick and the unused op only report status; stop also latches.
        send_request(OP_TICK,   request_bits(1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0));
        send_request(OP_STOP,   request_bits(1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0));
        send_request(OP_UNUSED, request_bits(1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1));
        // Zero target finishes at once and clears the stop latched while idle.
        send_request(OP_START,  request_bits(1'b1, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0));
        // Upward run cut short by the watchdog after three steps.
        send_request(OP_START,  request_bits(1'b1, 16'hFFFF, 16'h0003, 1'b0, 1'b0, 1'b1, 1'b1));
        repeat (4) send_request(OP_TICK,
            request_bits(1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b1));
        // Downward run to its target of two.
        send_request(OP_START,  request_bits(1'b0, 16'h0002, 16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b1));
        repeat (3) send_request(OP_TICK,
            request_bits(1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1));
        // Both limits on: the open count resets on an inactive read, closed reaches two.
        send_request(OP_START,  request_bits(1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1));
        send_request(OP_TICK,   request_bits(1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0));
        send_request(OP_TICK,   request_bits(1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b0));
        // Stop while running takes priority over an open limit about to trip.
        send_request(OP_START,  request_bits(1'b0, 16'h5555, 16'hAAAA, 1'b1, 1'b0, 1'b1, 1'b1));
        send_request(OP_TICK,   request_bits(1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1));
        send_request(OP_STOP,   request_bits(1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1));
        send_request(OP_UNUSED, request_bits(1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0));
        send_request(OP_TICK,   request_bits(1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1));
        // Restart mid-run, then a zero watchdog ends the new run on its first tick.
        send_request(OP_START,  request_bits(1'b1, 16'h0001, 16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b1));
        send_request(OP_TICK,   request_bits(1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b1));
        send_request(OP_START,  request_bits(1'b1, 16'h0005, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b1));
        send_request(OP_TICK,   request_bits(1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b1));
    endtask

    // One start followed by ticks with randomly active switch levels, mixed with stops and unused ops.
    task automatic random_run();
        logic [COUNT_WIDTH-1:0]   target;
        logic [COUNT_WIDTH-1:0]   wdog;
        logic [S_TDATA_WIDTH-1:0] data;
        int unsigned              roll;
        int unsigned              open_press_pct;
        int unsigned              clsd_press_pct;
        int unsigned              ticks;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            target = '0;
        end else if (roll < 8) begin
            target = COUNT_WIDTH'($urandom_range(1, 24));
        end else begin
            target = COUNT_WIDTH'($urandom);
        end
        roll = $urandom_range(0, 9);
        if (roll < 4) begin
            wdog = COUNT_WIDTH'($urandom_range(0, 30));
        end else if (roll < 7) begin
            wdog = '1;
        end else begin
            wdog = COUNT_WIDTH'($urandom);
        end
        open_press_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 97);
        clsd_press_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 97);
        tx_idle_pct    = pick_idle_pct();
        send_request(OP_START, request_bits(1'($urandom_range(0, 1)), target, wdog,
            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        ticks = $urandom_range(1, 40);
        repeat (ticks) begin
            roll = $urandom_range(0, 99);
            data = noise_bits();
            if (roll < 4) begin
                send_request(OP_STOP, data);
            end else if (roll < 7) begin
                send_request(OP_UNUSED, data);
            end else begin
                data[S_OPEN_LVL_BIT] = ($urandom_range(0, 99) < open_press_pct) ? 1'b0 : 1'b1;
                data[S_CLSD_LVL_BIT] = ($urandom_range(0, 99) < clsd_press_pct) ? 1'b0 : 1'b1;
                send_request(OP_TICK, data);
            end
        end
    endtask

    // Three hundred steps so step-count bits up to bit 8 move; the watchdog ends it.
    task automatic long_run();
        logic [S_TDATA_WIDTH-1:0] data;
        send_request(OP_START, request_bits(1'($urandom_range(0, 1)), 16'hFFFF, 16'd300,
            1'b0, 1'b0, 1'b1, 1'b1));
        repeat (301) begin
            data                 = noise_bits();
            data[S_OPEN_LVL_BIT] = 1'b1;
            data[S_CLSD_LVL_BIT] = 1'b1;
            send_request(OP_TICK, data);
        end
    endtask

    // Result side: random stall bursts in stretches, plus one long hold-off on demand.
    initial begin : result_sink
        int unsigned stall_pct;
        int unsigned stretch;
        stall_pct = 0;
        stretch   = 0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (stretch == 0) begin
                stall_pct = pick_idle_pct();
                stretch   = $urandom_range(20, 80);
            end
            stretch--;
            if (hold_off_request) begin
                // Hold off long enough for the result buffer to fill and stall the input.
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_request = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int unsigned           phase_no;
        int unsigned           phase_goal;
        logic [HITS_WIDTH-1:0] setting;
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part runs with the reset debounce of two.
        directed_requests();
        settle();

        for (phase_no = 0; phase_no < PHASE_COUNT; phase_no++) begin
            // Change the debounce only while idle: extremes first, then random values, last the reset value.
            case (phase_no)
                0:                 setting = 4'd1;
                1:                 setting = 4'd15;
                2:                 setting = 4'd0;
                PHASE_COUNT - 1:   setting = DEBOUNCE_RESET;
                default:           setting = HITS_WIDTH'($urandom_range(1, 15));
            endcase
            write_debounce(setting);
            if (phase_no == 1) begin
                hold_off_request = 1'b1;
            end
            if (phase_no == PHASE_COUNT - 1) begin
                quiet_tail = 1'b1;
            end
            phase_goal = requests_sent + PHASE_REQUESTS;
            if (phase_no == 3) begin
                long_run();
            end
            while (requests_sent < phase_goal) begin
                random_run();
            end
            settle();
        end

        // Allow stray replies to show up, then flag anything still owed.
        repeat (8) @(posedge aclk);
        if (sb.pending() != 0) begin
            sb.report_mismatch($sformatf("%0d status replies never arrived", sb.pending()));
        end
        if (sb.mismatches == 0) begin
            $display("half_step_stepper_run_engine_test: PASS");
        end else begin
            $display("half_step_stepper_run_engine_test: FAIL");
        end
        $finish;
    end

    // Hard limit, many times the slowest correct run.
    initial begin : run_limit
        #400_000;
        $display("half_step_stepper_run_engine_test: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
src/hssre_pkg.sv
src/half_step_stepper_run_engine.sv
src/hssre_checker.sv
test/half_step_stepper_run_engine_test.sv
